// ----- rtl/fcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fcce_pkg;
  localparam int unsigned TableEntriesDefault = 3072;
  localparam int LinkW = 12;
  localparam int LenW = 13;
  localparam logic [LinkW-1:0] AllocStartReset = 12'd3;
  localparam logic [LinkW-1:0] EndLow = 12'hFF8;
  localparam logic [LinkW-1:0] EndHigh = 12'hFFF;

  localparam logic [2:0] CMD_READ = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_FREE = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_LEN = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // Memory port command from the controller to the table memory.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [LinkW-1:0] addr;
    logic [LinkW-1:0] wdata;
  } mem_cmd_t;

  // Table status: clear pass flag and registered read data.
  typedef struct packed {
    logic             clearing;
    logic [LinkW-1:0] rdata;
  } mem_stat_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [LinkW-1:0] cluster;
    logic [LinkW-1:0] entry_value;
    logic [LinkW-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [LinkW-1:0] value;
    logic [LenW-1:0]  chain_length;
    logic [1:0]       status;
  } out_item_t;

  function automatic logic is_end(input logic [LinkW-1:0] link);
    return link >= EndLow;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/fcce_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fcce_in_if import fcce_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fcce_out_if import fcce_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fcce_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fcce_table import fcce_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mem_cmd_t  mcmd,
  output mem_stat_t      mstat
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  logic [LinkW-1:0] mem [TABLE_ENTRIES];
  logic [AW-1:0]    clr_addr;
  logic             clearing;
  logic [LinkW-1:0] rdata;

  // After reset every entry is zeroed, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(TABLE_ENTRIES - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (mcmd.wr) begin
      mem[mcmd.addr[AW-1:0]] <= mcmd.wdata;
    end
    if (mcmd.rd) rdata <= mem[mcmd.addr[AW-1:0]];
  end

  assign mstat.clearing = clearing;
  assign mstat.rdata = rdata;
endmodule
`default_nettype wire

// ----- rtl/fcce_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fcce_ctrl import fcce_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [LinkW-1:0] alloc_start,
  fcce_in_if.sink   in_ch,
  fcce_out_if.source out_ch,
  output mem_cmd_t  mcmd,
  input  wire mem_stat_t mstat
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_WCHK = 4'd3;
  localparam logic [3:0] S_CNT  = 4'd4;
  localparam logic [3:0] S_CCHK = 4'd5;
  localparam logic [3:0] S_ASCN = 4'd6;
  localparam logic [3:0] S_ACHK = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_RDR  = 4'd9;
  localparam logic [LenW-1:0] Ents = LenW'(TABLE_ENTRIES);

  logic [3:0]       state;
  logic [2:0]       cmd;
  logic [LinkW-1:0] cur;
  logic [LenW-1:0]  idx;
  logic [LinkW-1:0] need;
  logic [LinkW-1:0] found;
  logic [LinkW-1:0] last;
  logic             have;
  out_item_t        res;

  assign in_ch.ready = (state == S_IDLE) && !mstat.clearing;
  assign out_ch.valid = (state == S_DONE);
  assign out_ch.data = res;

  always_comb begin
    mcmd = '0;
    unique case (state)
      S_WALK: begin
        mcmd.rd = 1'b1;
        mcmd.addr = cur;
      end
      S_CNT, S_ASCN: begin
        mcmd.rd = 1'b1;
        mcmd.addr = idx[LinkW-1:0];
      end
      S_WCHK: begin
        mcmd.wr = (cmd == CMD_FREE);
        mcmd.addr = cur;
      end
      S_ACHK: begin
        // Link the previous free entry, if any, to this one; S_RDW closes the chain.
        if (mstat.rdata == '0 && have) begin
          mcmd.wr = 1'b1;
          mcmd.addr = last;
          mcmd.wdata = idx[LinkW-1:0];
        end
      end
      S_RDW: begin
        mcmd.wr = 1'b1;
        mcmd.addr = last;
        mcmd.wdata = EndHigh;
      end
      S_IDLE: begin
        mcmd.rd = 1'b1;
        mcmd.addr = in_ch.data.cluster;
        mcmd.wr = in_ch.valid && !mstat.clearing && in_ch.data.cmd == CMD_WRITE
                  && 32'(in_ch.data.cluster) < TABLE_ENTRIES;
        mcmd.wdata = in_ch.data.entry_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          cmd <= in_ch.data.cmd;
          cur <= in_ch.data.cluster;
          need <= in_ch.data.count;
          res.value <= '0;
          res.chain_length <= '0;
          have <= 1'b0;
          found <= '0;
          unique case (in_ch.data.cmd)
            CMD_READ: begin
              if (32'(in_ch.data.cluster) < TABLE_ENTRIES) begin
                res.status <= ST_OK;
                state <= S_RDR;
              end else begin
                res.status <= ST_RANGE;
                state <= S_DONE;
              end
            end
            CMD_WRITE: begin
              if (32'(in_ch.data.cluster) >= TABLE_ENTRIES) res.status <= ST_RANGE;
              else res.status <= ST_OK;
              state <= S_DONE;
            end
            CMD_FREE, CMD_LEN: begin
              res.status <= ST_OK;
              state <= S_WALK;
            end
            CMD_ALLOC: begin
              if (in_ch.data.count == '0) begin
                res.status <= ST_ZERO;
                state <= S_DONE;
              end else begin
                res.status <= ST_OK;
                idx <= LenW'(alloc_start);
                state <= S_CNT;
              end
            end
            default: begin
              res.status <= ST_OK;
              state <= S_DONE;
            end
          endcase
        end
        S_RDR: begin
          res.value <= mstat.rdata;
          state <= S_DONE;
        end
        S_WALK: begin
          if (32'(cur) >= TABLE_ENTRIES) begin
            res.status <= ST_RANGE;
            state <= S_DONE;
          end else state <= S_WCHK;
        end
        S_WCHK: begin
          res.chain_length <= res.chain_length + 1'b1;
          cur <= mstat.rdata;
          if (is_end(mstat.rdata)) state <= S_DONE;
          else if (res.chain_length + 1'b1 >= Ents) begin
            res.status <= ST_RANGE;
            state <= S_DONE;
          end else state <= S_WALK;
        end
        S_CNT: begin
          if (idx >= Ents) begin
            res.status <= ST_NOSPACE;
            state <= S_DONE;
          end else state <= S_CCHK;
        end
        S_CCHK: begin
          if (mstat.rdata == '0 && found + 1'b1 == need) begin
            idx <= LenW'(alloc_start);
            found <= '0;
            state <= S_ASCN;
          end else begin
            if (mstat.rdata == '0) found <= found + 1'b1;
            idx <= idx + 1'b1;
            state <= S_CNT;
          end
        end
        S_ASCN: state <= S_ACHK;
        S_ACHK: begin
          if (mstat.rdata == '0) begin
            if (!have) res.value <= idx[LinkW-1:0];
            have <= 1'b1;
            last <= idx[LinkW-1:0];
            found <= found + 1'b1;
            if (found + 1'b1 == need) state <= S_RDW;
            else begin
              idx <= idx + 1'b1;
              state <= S_ASCN;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_ASCN;
          end
        end
        S_RDW: state <= S_DONE;
        S_DONE: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fat12_cluster_chain_engine_unit.sv -----
`timescale 1ns / 1ps
// FAT12 cluster chain engine.
// Input channel in_ch carries one command item (cmd, cluster, entry_value,
// count); output channel out_ch returns one result item (value, chain_length,
// status) per command. Both use valid/ready; an item moves when both are high.
// alloc_start is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// One item is worked at a time against the table memory, which takes one
// read and/or write command per cycle. Free and length walk the chain link
// by link; allocate scans entries from alloc_start twice, once to count free
// entries and once to link them.
// After reset the table is zeroed one entry a cycle, during which no item is
// accepted. A result waits in its register while the receiver stalls, and
// the next item is taken once it has gone.
`default_nettype none
module fat12_cluster_chain_engine_unit import fcce_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [LinkW-1:0] cfg_wdata,
  fcce_in_if.sink   in_ch,
  fcce_out_if.source out_ch
);
  logic [LinkW-1:0] alloc_start;
  mem_cmd_t  mcmd;
  mem_stat_t mstat;

  always_ff @(posedge clk) begin
    if (rst) alloc_start <= AllocStartReset;
    else if (cfg_we) alloc_start <= cfg_wdata;
  end

  fcce_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk(clk), .rst(rst), .mcmd(mcmd), .mstat(mstat)
  );

  fcce_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk(clk), .rst(rst), .alloc_start(alloc_start),
    .in_ch(in_ch), .out_ch(out_ch), .mcmd(mcmd), .mstat(mstat)
  );
endmodule
`default_nettype wire
